@@ hdl/btxq_pkg.sv @@
// Package for the binary trie XOR query block: payload structs, codes and sequencer states.
// Has no dependencies. binary_trie_xor_query and the testbench use it; btxq_node_mem does not.
package btxq_pkg;

   localparam int KEY_BITS = 31;
   localparam int LEVEL_W  = 5;
   localparam int CSR_AW   = 3;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_ERASE  = 2'd1,
      OP_QMAX   = 2'd2,
      OP_QMIN   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_EMPTY  = 2'd1,
      ST_REJECT = 2'd2,
      ST_ABSENT = 2'd3
   } status_type;

   localparam logic REG_TOP_BIT = 1'b0;

   typedef struct packed {
      logic [1:0]          operation;
      logic [KEY_BITS-1:0] key_value;
   } req_type;

   typedef struct packed {
      logic [KEY_BITS-1:0] xor_result;
      logic [1:0]          status;
   } rsp_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_LINK,
      S_CNT,
      S_EXEC,
      S_ROOM,
      S_ALLOC2
   } state_type;

   typedef enum logic [2:0] {
      M_CHK_INS,
      M_MOD_INS,
      M_CHK_ERA,
      M_MOD_ERA,
      M_QUERY
   } mode_type;

endpackage

@@ hdl/btxq_node_mem.sv @@
// Node pool storage: zero-child links, one-child links and use counts.
// Uses no package items; instantiated by binary_trie_xor_query.
module btxq_node_mem #(
   parameter int NODE_COUNT = 4096,
   parameter int COUNT_BITS = 16,
   parameter int IDX_W      = $clog2(NODE_COUNT)
) (
   input  logic                  clock,
   input  logic [IDX_W-1:0]      link_rd_addr,
   output logic [IDX_W-1:0]      zero_rd,
   output logic [IDX_W-1:0]      one_rd,
   input  logic [IDX_W-1:0]      cnt_rd_addr_a,
   input  logic [IDX_W-1:0]      cnt_rd_addr_b,
   output logic [COUNT_BITS-1:0] cnt_rd_a,
   output logic [COUNT_BITS-1:0] cnt_rd_b,
   input  logic                  zero_we,
   input  logic                  one_we,
   input  logic [IDX_W-1:0]      link_wr_addr,
   input  logic [IDX_W-1:0]      link_wr_data,
   input  logic                  cnt_we,
   input  logic [IDX_W-1:0]      cnt_wr_addr,
   input  logic [COUNT_BITS-1:0] cnt_wr_data
);

   logic [IDX_W-1:0]      zero_mem [NODE_COUNT];
   logic [IDX_W-1:0]      one_mem  [NODE_COUNT];
   logic [COUNT_BITS-1:0] cnt_mem  [NODE_COUNT];

   always_ff @(posedge clock) begin
      if (zero_we) begin
         zero_mem[link_wr_addr] <= link_wr_data;
      end
      zero_rd <= zero_mem[link_rd_addr];
   end

   always_ff @(posedge clock) begin
      if (one_we) begin
         one_mem[link_wr_addr] <= link_wr_data;
      end
      one_rd <= one_mem[link_rd_addr];
   end

   always_ff @(posedge clock) begin
      if (cnt_we) begin
         cnt_mem[cnt_wr_addr] <= cnt_wr_data;
      end
      cnt_rd_a <= cnt_mem[cnt_rd_addr_a];
      cnt_rd_b <= cnt_mem[cnt_rd_addr_b];
   end

endmodule

@@ hdl/binary_trie_xor_query.sv @@
// Top level of the binary trie XOR query block: sequencer, register port and root links.
// Depends on btxq_pkg and btxq_node_mem.
//
//   channel   ports                              transaction marker
//   request   start, busy, req_item              start high while busy low
//   result    rsp_strobe, rsp_item               rsp_strobe high for one cycle
//   config    psel penable pwrite paddr pwdata   psel & penable & pwrite & pready
//
// Each key level passes through link read, count read and decide (S_LINK, S_CNT, S_EXEC),
// and a newly allocated node through S_ALLOC2 as well. With T the top bit in use, a walk
// runs from level T down to 0 and may stop early; an insert checks, passes S_ROOM and then
// walks again to modify, and a full erase walks all T+1 levels twice.
// The result shows in the first cycle with busy low again.
// An item answered at once (full total, empty set) gives its result the next cycle.
// Reset is synchronous; no clearing pass is needed, nodes are zeroed on allocation.
// The receiver cannot stall; each result is shown for exactly one cycle.
module binary_trie_xor_query #(
   parameter int NODE_COUNT = 4096,
   parameter int COUNT_BITS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  btxq_pkg::req_type                 req_item,
   output logic                              rsp_strobe,
   output btxq_pkg::rsp_type                 rsp_item,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [btxq_pkg::CSR_AW-1:0]       paddr,
   input  logic [31:0]                       pwdata,
   output logic [31:0]                       prdata,
   output logic                              pready
);

   localparam int IDX_W  = $clog2(NODE_COUNT);
   localparam int FREE_W = IDX_W + 1;
   localparam int ROOM_W = IDX_W + 2;
   localparam int LW     = btxq_pkg::LEVEL_W;
   localparam int KB     = btxq_pkg::KEY_BITS;
   localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

   btxq_pkg::state_type state_ff, state_in;
   btxq_pkg::mode_type  mode_ff, mode_in;
   logic [1:0]          op_ff, op_in;
   logic [KB-1:0]       key_ff, key_in;
   logic [LW-1:0]       level_ff, level_in;
   logic [IDX_W-1:0]    node_ff, node_in;
   logic [KB-1:0]       answer_ff, answer_in;
   logic [LW-1:0]       need_ff, need_in;
   logic [IDX_W-1:0]    root_zero_ff, root_zero_in, root_one_ff, root_one_in;
   logic [IDX_W-1:0]    z_ff, z_in, o_ff, o_in;
   logic [FREE_W-1:0]   next_free_ff, next_free_in;
   logic [COUNT_BITS-1:0] total_ff, total_in;
   logic [LW-1:0]       top_ff, top_in;
   btxq_pkg::rsp_type   rsp_ff, rsp_in;
   logic                rsp_strobe_ff, rsp_strobe_in;

   logic [IDX_W-1:0]      zero_rd, one_rd, link_z, link_o;
   logic [COUNT_BITS-1:0] cnt_z, cnt_o, ck, cnt_sum;
   logic                  zero_we, one_we, cnt_we;
   logic [IDX_W-1:0]      link_wr_addr, link_wr_data, cnt_wr_addr;
   logic [COUNT_BITS-1:0] cnt_wr_data;

   logic [LW-1:0]    top_eff;
   logic             accept, is_ins, imm_done, key_bit, last, missing;
   logic [IDX_W-1:0] lk, first, second;
   logic             greatest, live_first, live_second;
   logic             fin_exec, to_room, to_alloc, room_ok, csr_write;
   btxq_pkg::status_type fin_status;

   btxq_node_mem #(
      .NODE_COUNT (NODE_COUNT),
      .COUNT_BITS (COUNT_BITS),
      .IDX_W      (IDX_W)
   ) u_mem (
      .clock         (clock),
      .link_rd_addr  (node_ff),
      .zero_rd       (zero_rd),
      .one_rd        (one_rd),
      .cnt_rd_addr_a (link_z),
      .cnt_rd_addr_b (link_o),
      .cnt_rd_a      (cnt_z),
      .cnt_rd_b      (cnt_o),
      .zero_we       (zero_we),
      .one_we        (one_we),
      .link_wr_addr  (link_wr_addr),
      .link_wr_data  (link_wr_data),
      .cnt_we        (cnt_we),
      .cnt_wr_addr   (cnt_wr_addr),
      .cnt_wr_data   (cnt_wr_data)
   );

   assign busy       = (state_ff != btxq_pkg::S_IDLE);
   assign accept     = start && !busy;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_ff;
   assign pready     = 1'b1;
   assign csr_write  = psel && penable && pwrite && pready;
   assign prdata     = (paddr[2] == btxq_pkg::REG_TOP_BIT) ? {27'd0, top_ff} : 32'd0;

   assign top_eff = (top_ff >= LW'(KB)) ? LW'(KB - 1) : top_ff;
   assign is_ins  = (req_item.operation == btxq_pkg::OP_INSERT);
   assign imm_done = is_ins ? (total_ff == CNT_MAX) : (total_ff == '0);

   // The root's links live in flip-flops so that reset clears them at once.
   assign link_z = (node_ff == '0) ? root_zero_ff : zero_rd;
   assign link_o = (node_ff == '0) ? root_one_ff : one_rd;

   assign key_bit = key_ff[level_ff];
   assign last    = (level_ff == '0);
   assign lk      = key_bit ? o_ff : z_ff;
   assign ck      = key_bit ? cnt_o : cnt_z;
   assign missing = (lk == '0);
   assign cnt_sum = ck + ((mode_ff == btxq_pkg::M_MOD_ERA) ? CNT_MAX : COUNT_BITS'(1));

   assign greatest    = (op_ff == btxq_pkg::OP_QMAX);
   assign first       = (greatest ^ key_bit) ? o_ff : z_ff;
   assign second      = (greatest ^ key_bit) ? z_ff : o_ff;
   assign live_first  = (first != '0) && (((greatest ^ key_bit) ? cnt_o : cnt_z) != '0);
   assign live_second = (second != '0) && (((greatest ^ key_bit) ? cnt_z : cnt_o) != '0);

   assign room_ok = (ROOM_W'(need_ff) + ROOM_W'(next_free_ff)) <= ROOM_W'(NODE_COUNT);

   always_comb begin
      fin_exec   = 1'b0;
      to_room    = 1'b0;
      to_alloc   = 1'b0;
      fin_status = btxq_pkg::ST_OK;
      case (mode_ff)
         btxq_pkg::M_CHK_INS: begin
            if (!missing && ck == CNT_MAX) begin
               fin_exec   = 1'b1;
               fin_status = btxq_pkg::ST_REJECT;
            end else begin
               to_room = missing || last;
            end
         end
         btxq_pkg::M_MOD_INS: begin
            to_alloc = missing;
            fin_exec = !missing && last;
         end
         btxq_pkg::M_CHK_ERA: begin
            if (missing || ck == '0) begin
               fin_exec   = 1'b1;
               fin_status = btxq_pkg::ST_ABSENT;
            end
         end
         btxq_pkg::M_MOD_ERA: fin_exec = last;
         btxq_pkg::M_QUERY:   fin_exec = last || !(live_first || live_second);
         default:             fin_exec = 1'b1;
      endcase
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         btxq_pkg::S_IDLE: begin
            if (accept && !imm_done) begin
               state_in = btxq_pkg::S_LINK;
            end
         end
         btxq_pkg::S_LINK: state_in = btxq_pkg::S_CNT;
         btxq_pkg::S_CNT:  state_in = btxq_pkg::S_EXEC;
         btxq_pkg::S_EXEC: begin
            if (fin_exec) begin
               state_in = btxq_pkg::S_IDLE;
            end else if (to_room) begin
               state_in = btxq_pkg::S_ROOM;
            end else if (to_alloc) begin
               state_in = btxq_pkg::S_ALLOC2;
            end else begin
               state_in = btxq_pkg::S_LINK;
            end
         end
         btxq_pkg::S_ROOM:   state_in = room_ok ? btxq_pkg::S_LINK : btxq_pkg::S_IDLE;
         btxq_pkg::S_ALLOC2: state_in = last ? btxq_pkg::S_IDLE : btxq_pkg::S_LINK;
         default:            state_in = btxq_pkg::S_IDLE;
      endcase
   end

   // Datapath and memory controls.
   always_comb begin
      mode_in       = mode_ff;
      op_in         = op_ff;
      key_in        = key_ff;
      level_in      = level_ff;
      node_in       = node_ff;
      answer_in     = answer_ff;
      need_in       = need_ff;
      root_zero_in  = root_zero_ff;
      root_one_in   = root_one_ff;
      z_in          = z_ff;
      o_in          = o_ff;
      next_free_in  = next_free_ff;
      total_in      = total_ff;
      top_in        = top_ff;
      rsp_in        = rsp_ff;
      rsp_strobe_in = 1'b0;
      zero_we       = 1'b0;
      one_we        = 1'b0;
      link_wr_addr  = node_ff;
      link_wr_data  = '0;
      cnt_we        = 1'b0;
      cnt_wr_addr   = lk;
      cnt_wr_data   = cnt_sum;

      if (csr_write && paddr[2] == btxq_pkg::REG_TOP_BIT) begin
         top_in = pwdata[LW-1:0];
      end

      case (state_ff)
         btxq_pkg::S_IDLE: begin
            if (accept) begin
               op_in     = req_item.operation;
               key_in    = req_item.key_value;
               level_in  = top_eff;
               node_in   = '0;
               answer_in = '0;
               case (req_item.operation)
                  btxq_pkg::OP_INSERT: mode_in = btxq_pkg::M_CHK_INS;
                  btxq_pkg::OP_ERASE:  mode_in = btxq_pkg::M_CHK_ERA;
                  default:             mode_in = btxq_pkg::M_QUERY;
               endcase
               if (imm_done) begin
                  rsp_strobe_in     = 1'b1;
                  rsp_in.xor_result = '0;
                  case (req_item.operation)
                     btxq_pkg::OP_INSERT: rsp_in.status = btxq_pkg::ST_REJECT;
                     btxq_pkg::OP_ERASE:  rsp_in.status = btxq_pkg::ST_ABSENT;
                     default:             rsp_in.status = btxq_pkg::ST_EMPTY;
                  endcase
               end
            end
         end
         btxq_pkg::S_CNT: begin
            z_in = link_z;
            o_in = link_o;
         end
         btxq_pkg::S_EXEC: begin
            case (mode_ff)
               btxq_pkg::M_CHK_INS: begin
                  need_in = missing ? level_ff + LW'(1) : '0;
                  node_in = lk;
               end
               btxq_pkg::M_MOD_INS: begin
                  if (missing) begin
                     // Hook a fresh node under the current one; its links follow next cycle.
                     if (node_ff == '0) begin
                        if (key_bit) begin
                           root_one_in = next_free_ff[IDX_W-1:0];
                        end else begin
                           root_zero_in = next_free_ff[IDX_W-1:0];
                        end
                     end else begin
                        zero_we = !key_bit;
                        one_we  = key_bit;
                     end
                     link_wr_data = next_free_ff[IDX_W-1:0];
                     cnt_we       = 1'b1;
                     cnt_wr_addr  = next_free_ff[IDX_W-1:0];
                     cnt_wr_data  = COUNT_BITS'(1);
                     node_in      = next_free_ff[IDX_W-1:0];
                     next_free_in = next_free_ff + FREE_W'(1);
                  end else begin
                     cnt_we  = 1'b1;
                     node_in = lk;
                  end
               end
               btxq_pkg::M_CHK_ERA: node_in = lk;
               btxq_pkg::M_MOD_ERA: begin
                  cnt_we  = 1'b1;
                  node_in = lk;
               end
               btxq_pkg::M_QUERY: begin
                  if (live_first) begin
                     answer_in[level_ff] = greatest;
                     node_in = first;
                  end else if (live_second) begin
                     answer_in[level_ff] = !greatest;
                     node_in = second;
                  end
               end
               default: node_in = node_ff;
            endcase

            if (fin_exec) begin
               rsp_strobe_in     = 1'b1;
               rsp_in.status     = fin_status;
               rsp_in.xor_result = (mode_ff == btxq_pkg::M_QUERY) ? answer_in : '0;
               if (mode_ff == btxq_pkg::M_MOD_INS) begin
                  total_in = total_ff + COUNT_BITS'(1);
               end else if (mode_ff == btxq_pkg::M_MOD_ERA) begin
                  total_in = total_ff - COUNT_BITS'(1);
               end
            end else if (mode_ff == btxq_pkg::M_CHK_ERA && last) begin
               // The key is present; walk again and take one copy off each node.
               mode_in  = btxq_pkg::M_MOD_ERA;
               level_in = top_eff;
               node_in  = '0;
            end else if (!to_room && !to_alloc) begin
               level_in = level_ff - LW'(1);
            end
         end
         btxq_pkg::S_ROOM: begin
            if (room_ok) begin
               mode_in  = btxq_pkg::M_MOD_INS;
               level_in = top_eff;
               node_in  = '0;
            end else begin
               rsp_strobe_in     = 1'b1;
               rsp_in.status     = btxq_pkg::ST_REJECT;
               rsp_in.xor_result = '0;
            end
         end
         btxq_pkg::S_ALLOC2: begin
            zero_we      = 1'b1;
            one_we       = 1'b1;
            link_wr_data = '0;
            if (last) begin
               rsp_strobe_in     = 1'b1;
               rsp_in.status     = btxq_pkg::ST_OK;
               rsp_in.xor_result = '0;
               total_in          = total_ff + COUNT_BITS'(1);
            end else begin
               level_in = level_ff - LW'(1);
            end
         end
         default: node_in = node_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= btxq_pkg::S_IDLE;
         root_zero_ff  <= '0;
         root_one_ff   <= '0;
         next_free_ff  <= FREE_W'(1);
         total_ff      <= '0;
         top_ff        <= LW'(30);
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         root_zero_ff  <= root_zero_in;
         root_one_ff   <= root_one_in;
         next_free_ff  <= next_free_in;
         total_ff      <= total_in;
         top_ff        <= top_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff   <= mode_in;
      op_ff     <= op_in;
      key_ff    <= key_in;
      level_ff  <= level_in;
      node_ff   <= node_in;
      answer_ff <= answer_in;
      need_ff   <= need_in;
      z_ff      <= z_in;
      o_ff      <= o_in;
      rsp_ff    <= rsp_in;
   end

   a_free_bound: assert property (@(posedge clock) disable iff (reset)
      next_free_ff <= FREE_W'(NODE_COUNT))
      else $error("node pool pointer ran past the pool");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_item.status == btxq_pkg::ST_EMPTY |-> rsp_item.xor_result == '0)
      else $error("empty query returned a nonzero result");

   a_total_step: assert property (@(posedge clock) disable iff (reset)
      !rsp_strobe_in |=> total_ff == $past(total_ff))
      else $error("key total changed without a finishing transaction");

   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result strobe while the sequencer is still working");

endmodule

@@ verif/tb_binary_trie_xor_query.sv @@
// Self-checking testbench for binary_trie_xor_query: predicts every trie operation from
// its own copy of the node pool and checks each result. Depends on btxq_pkg and the RTL.
`timescale 1ns / 100ps
module tb_binary_trie_xor_query;

   localparam int          POOL_SIZE = 4096;
   localparam logic [15:0] COUNT_TOP = 16'hFFFF;
   localparam int          SETTLE    = 250;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        start = 1'b0;
   logic                        busy;
   btxq_pkg::req_type           req_item = '0;
   logic                        rsp_strobe;
   btxq_pkg::rsp_type           rsp_item;
   logic                        psel = 1'b0;
   logic                        penable = 1'b0;
   logic                        pwrite = 1'b0;
   logic [btxq_pkg::CSR_AW-1:0] paddr = '0;
   logic [31:0]                 pwdata = '0;
   logic [31:0]                 prdata;
   logic                        pready;

   // Trie mirror.
   logic [11:0] zero_lk [POOL_SIZE];
   logic [11:0] one_lk  [POOL_SIZE];
   logic [15:0] use_cnt [POOL_SIZE];
   logic [12:0] free_node;
   logic [15:0] key_total;
   logic [4:0]  top_reg;

   btxq_pkg::req_type pending_items [$];
   btxq_pkg::rsp_type expected_rsp [$];
   logic [30:0]       key_bank [$];
   int                burst_left = 0;
   int                gap_left = 0;
   int                mismatches = 0;

   binary_trie_xor_query uut (
      .clock, .reset, .start, .busy, .req_item, .rsp_strobe, .rsp_item,
      .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
   );

   always #5 clock = ~clock;

   function automatic int level_top();
      return (top_reg >= 5'd31) ? 30 : int'(top_reg);
   endfunction

   function automatic logic [11:0] child_of(int n, logic b);
      return b ? one_lk[n] : zero_lk[n];
   endfunction

   function automatic bit is_live(logic [11:0] lk);
      return lk != 0 && use_cnt[lk] != 0;
   endfunction

   function automatic btxq_pkg::status_type trie_insert(logic [30:0] key);
      int          node;
      int          need;
      logic [11:0] lk;
      node = 0;
      need = 0;
      if (key_total == COUNT_TOP) return btxq_pkg::ST_REJECT;
      for (int i = level_top(); i >= 0; i--) begin
         lk = child_of(node, key[i]);
         if (lk == 0) begin
            need = i + 1;
            break;
         end
         if (use_cnt[lk] == COUNT_TOP) return btxq_pkg::ST_REJECT;
         node = lk;
      end
      if (need > POOL_SIZE - int'(free_node)) return btxq_pkg::ST_REJECT;
      node = 0;
      for (int i = level_top(); i >= 0; i--) begin
         lk = child_of(node, key[i]);
         if (lk == 0) begin
            lk = free_node[11:0];
            free_node = free_node + 1;
            zero_lk[lk] = '0;
            one_lk[lk] = '0;
            use_cnt[lk] = '0;
            if (key[i]) one_lk[node] = lk;
            else zero_lk[node] = lk;
         end
         use_cnt[lk] = use_cnt[lk] + 1;
         node = lk;
      end
      key_total = key_total + 1;
      return btxq_pkg::ST_OK;
   endfunction

   function automatic btxq_pkg::status_type trie_erase(logic [30:0] key);
      int          node;
      logic [11:0] lk;
      node = 0;
      if (key_total == 0) return btxq_pkg::ST_ABSENT;
      for (int i = level_top(); i >= 0; i--) begin
         lk = child_of(node, key[i]);
         if (!is_live(lk)) return btxq_pkg::ST_ABSENT;
         node = lk;
      end
      node = 0;
      for (int i = level_top(); i >= 0; i--) begin
         node = child_of(node, key[i]);
         use_cnt[node] = use_cnt[node] - 1;
      end
      key_total = key_total - 1;
      return btxq_pkg::ST_OK;
   endfunction

   function automatic logic [30:0] trie_best_xor(logic [30:0] key, bit greatest);
      int          node;
      logic [11:0] same_lk;
      logic [11:0] other_lk;
      logic [11:0] first_lk;
      logic [11:0] second_lk;
      logic [30:0] answer;
      node = 0;
      answer = '0;
      for (int i = level_top(); i >= 0; i--) begin
         same_lk = child_of(node, key[i]);
         other_lk = child_of(node, ~key[i]);
         first_lk = greatest ? other_lk : same_lk;
         second_lk = greatest ? same_lk : other_lk;
         if (is_live(first_lk)) begin
            if (greatest) answer[i] = 1'b1;
            node = first_lk;
         end else if (is_live(second_lk)) begin
            if (!greatest) answer[i] = 1'b1;
            node = second_lk;
         end else begin
            break;
         end
      end
      return answer;
   endfunction

   function automatic btxq_pkg::rsp_type trie_result(btxq_pkg::req_type item);
      btxq_pkg::rsp_type r;
      r = '0;
      case (btxq_pkg::op_type'(item.operation))
         btxq_pkg::OP_INSERT: r.status = trie_insert(item.key_value);
         btxq_pkg::OP_ERASE:  r.status = trie_erase(item.key_value);
         default: begin
            if (key_total == 0) r.status = btxq_pkg::ST_EMPTY;
            else begin
               r.status = btxq_pkg::ST_OK;
               r.xor_result = trie_best_xor(item.key_value,
                                            item.operation == btxq_pkg::OP_QMAX);
            end
         end
      endcase
      return r;
   endfunction

   // Request driver: bursts of back-to-back transactions separated by random gaps.
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         gap_left <= 0;
         burst_left <= 0;
      end else if (start && !busy) begin
         expected_rsp = {expected_rsp, trie_result(req_item)};
         if (burst_left > 0 && pending_items.size() > 0) begin
            req_item <= pending_items.pop_front();
            burst_left <= burst_left - 1;
         end else begin
            start <= 1'b0;
            gap_left <= $urandom_range(0, 6);
         end
      end else if (!start) begin
         if (gap_left > 0) begin
            gap_left <= gap_left - 1;
         end else if (pending_items.size() > 0) begin
            req_item <= pending_items.pop_front();
            start <= 1'b1;
            burst_left <= ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(0, 8);
         end
      end
   end

   // Result monitor.
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (expected_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("Unexpected result transaction: xor %h status %0d",
                        rsp_item.xor_result, rsp_item.status);
         end else begin
            btxq_pkg::rsp_type want;
            want = expected_rsp.pop_front();
            if (rsp_item.xor_result !== want.xor_result || rsp_item.status !== want.status) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("Mismatch: expected xor %h status %0d, got xor %h status %0d",
                           want.xor_result, want.status, rsp_item.xor_result, rsp_item.status);
            end
         end
      end
   end

   task automatic write_top_bit(logic [4:0] value);
      @(posedge clock);
      psel <= 1'b1;
      pwrite <= 1'b1;
      penable <= 1'b0;
      paddr <= btxq_pkg::CSR_AW'({btxq_pkg::REG_TOP_BIT, 2'b00});
      pwdata <= 32'(value);
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      top_reg = value;
   endtask

   task automatic queue_item(btxq_pkg::op_type op, logic [30:0] key);
      btxq_pkg::req_type item;
      item.operation = op;
      item.key_value = key;
      pending_items = {pending_items, item};
   endtask

   task automatic wait_drained();
      while (pending_items.size() != 0 || start || expected_rsp.size() != 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // Random traffic biased toward keys already stored so that erases hit and paths share.
   task automatic queue_random(int count);
      int          pick;
      logic [30:0] key;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(0, 99);
         key = 31'($urandom);
         if (key_bank.size() > 0 && $urandom_range(0, 2) != 0)
            key = key_bank[$urandom_range(0, key_bank.size() - 1)] ^ 31'($urandom_range(0, 3));
         if (pick < 40) begin
            queue_item(btxq_pkg::OP_INSERT, key);
            key_bank = {key_bank, key};
            if (key_bank.size() > 64) void'(key_bank.pop_front());
         end else if (pick < 65) begin
            queue_item(btxq_pkg::OP_ERASE, key);
         end else if (pick < 85) begin
            queue_item(btxq_pkg::OP_QMAX, key);
         end else begin
            queue_item(btxq_pkg::OP_QMIN, key);
         end
      end
   endtask

   initial begin
      logic [4:0] tops [10];
      tops = '{5'd3, 5'd0, 5'd7, 5'd5, 5'd10, 5'd2, 5'd12, 5'd31, 5'd4, 5'd6};
      zero_lk[0] = '0;
      one_lk[0] = '0;
      use_cnt[0] = '0;
      free_node = 13'd1;
      key_total = '0;
      top_reg = 5'd30;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      write_top_bit(5'd30);

      // Directed: empty set, absent erase, extreme keys, duplicates, back to empty.
      queue_item(btxq_pkg::OP_QMAX, 31'h0);
      queue_item(btxq_pkg::OP_QMIN, 31'h7FFFFFFF);
      queue_item(btxq_pkg::OP_ERASE, 31'h0);
      queue_item(btxq_pkg::OP_INSERT, 31'h0);
      queue_item(btxq_pkg::OP_INSERT, 31'h7FFFFFFF);
      queue_item(btxq_pkg::OP_INSERT, 31'h7FFFFFFF);
      queue_item(btxq_pkg::OP_QMAX, 31'h0);
      queue_item(btxq_pkg::OP_QMIN, 31'h0);
      queue_item(btxq_pkg::OP_QMAX, 31'h7FFFFFFF);
      queue_item(btxq_pkg::OP_QMIN, 31'h55555555);
      queue_item(btxq_pkg::OP_ERASE, 31'h7FFFFFFF);
      queue_item(btxq_pkg::OP_ERASE, 31'h7FFFFFFF);
      queue_item(btxq_pkg::OP_ERASE, 31'h7FFFFFFF);
      queue_item(btxq_pkg::OP_ERASE, 31'h0);
      queue_item(btxq_pkg::OP_QMIN, 31'h2AAAAAAA);
      queue_item(btxq_pkg::OP_INSERT, 31'h2AAAAAAA);
      queue_item(btxq_pkg::OP_INSERT, 31'h55555555);
      queue_item(btxq_pkg::OP_QMAX, 31'h2AAAAAAA);
      queue_item(btxq_pkg::OP_QMIN, 31'h55555554);
      queue_item(btxq_pkg::OP_ERASE, 31'h12345678);
      wait_drained();

      // Each phase changes the examined depth with keys still stored, which exercises
      // dead ends and reuse of links under a different bit meaning.
      foreach (tops[p]) begin
         write_top_bit(tops[p]);
         queue_random(190);
         wait_drained();
      end

      if (expected_rsp.size() != 0) mismatches++;
      if (mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("== FAIL ==");
      $finish;
   end

endmodule
